@@ sv/mpsp_pkg.sv @@
// Package for the play-string parser: codes, types, tables and helper functions.
package mpsp_pkg;

  localparam int unsigned DIV_STEPS = 21;
  localparam logic [20:0] FREQ_NUM  = 21'd1193180;

  localparam logic [15:0] WHOLE_RST = 16'd1000;
  localparam logic [7:0]  VOL_RST   = 8'd10;
  localparam logic [3:0]  OCT_RST   = 4'd4;
  localparam logic [2:0]  LEN_RST   = 3'd2;
  localparam logic [3:0]  OCT_MIN   = 4'd1;
  localparam logic [3:0]  OCT_MAX   = 4'd8;

  typedef enum logic [2:0] {
    KIND_NOTE = 3'd0,
    KIND_REST = 3'd1,
    KIND_BAD  = 3'd2,
    KIND_END  = 3'd3,
    KIND_OFF  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CFG_WHOLE = 2'd0,
    CFG_VOL   = 2'd1,
    CFG_EN    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         note;
    logic [3:0]         oct;
    logic signed [7:0]  midi;
    logic [15:0]        dur;
    logic [7:0]         vol;
  } slot_t;

  function automatic logic [15:0] div_entry(input logic [3:0] idx);
    logic [15:0] d;
    case (idx)
      4'd0:    d = 16'd19327;
      4'd1:    d = 16'd18242;
      4'd2:    d = 16'd17218;
      4'd3:    d = 16'd16252;
      4'd4:    d = 16'd15340;
      4'd5:    d = 16'd14479;
      4'd6:    d = 16'd13666;
      4'd7:    d = 16'd12899;
      4'd8:    d = 16'd12175;
      4'd9:    d = 16'd11492;
      4'd10:   d = 16'd10847;
      4'd11:   d = 16'd10238;
      4'd12:   d = 16'd9664;
      default: d = 16'd9121;
    endcase
    return d;
  endfunction

  // semitone base of a lowercase letter a..g
  function automatic logic [3:0] letter_base(input logic [7:0] c);
    logic [3:0] b;
    case (c)
      "a":     b = 4'd10;
      "b":     b = 4'd12;
      "c":     b = 4'd1;
      "d":     b = 4'd3;
      "e":     b = 4'd5;
      "f":     b = 4'd6;
      "g":     b = 4'd8;
      default: b = 4'd0;
    endcase
    return b;
  endfunction

  // {hit, shift} for a length digit
  function automatic logic [3:0] len_code(input logic [7:0] c);
    logic [3:0] r;
    case (c)
      "1":     r = {1'b1, 3'd0};
      "2":     r = {1'b1, 3'd1};
      "4":     r = {1'b1, 3'd2};
      "8":     r = {1'b1, 3'd3};
      "6":     r = {1'b1, 3'd4};
      "3":     r = {1'b1, 3'd5};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic slot_t plain_slot(input kind_t k, input logic [15:0] dur);
    slot_t s;
    s.kind = k;
    s.note = 4'd0;
    s.oct  = 4'd0;
    s.midi = -8'sd1;
    s.dur  = dur;
    s.vol  = 8'd0;
    return s;
  endfunction

  function automatic slot_t note_slot(input logic [3:0] base, input logic signed [1:0] off,
                                      input logic [3:0] oct, input logic [15:0] dur,
                                      input logic [7:0] vol);
    logic signed [5:0] n;
    logic [3:0]        ni;
    logic [3:0]        o;
    slot_t             s;
    n = $signed({2'b00, base}) + $signed({{4{off[1]}}, off});
    if (n < 6'sd0) begin
      ni = 4'd0;
    end else if (n > 6'sd13) begin
      ni = 4'd13;
    end else begin
      ni = n[3:0];
    end
    o = (oct > OCT_MAX) ? OCT_MAX : oct;
    s.kind = KIND_NOTE;
    s.note = ni;
    s.oct  = o;
    s.midi = $signed(8'(ni) - 8'd1 + 8'({o, 3'b000}) + 8'({o, 2'b00}));
    s.dur  = dur;
    s.vol  = vol;
    return s;
  endfunction

endpackage

@@ sv/mpsp_div.sv @@
// Bit-serial restoring divider: fixed frequency numerator over a 16-bit divisor.
module mpsp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  import mpsp_pkg::*;

  localparam int unsigned CW = $clog2(DIV_STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(DIV_STEPS - 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [15:0]   rem_r;
  logic [15:0]   d_r;
  logic [20:0]   q_r;
  logic [16:0]   trial;
  logic          fits;

  assign trial = {rem_r, q_r[20]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      q_r   <= FREQ_NUM;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? 16'(trial - {1'b0, d_r}) : trial[15:0];
      q_r   <= {q_r[19:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r[15:0];

endmodule

@@ sv/music_play_string_parser_top.sv @@
// Play-string parser top level: character decode, state, result slots and sequencer.
// Timing: a non-note result is shown in the cycle after the character transaction;
// a note passes through ST_LOAD and ST_DIV, where the 21-step serial divider
// forms its frequency, before ST_OUT shows it. in_stall stays high until all
// results of the character are taken; no new character is accepted before then.
// Reset (rst_n low, synchronous): registers to defaults, octave 4, quarter notes.
module music_play_string_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic              in_end_of_string,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic signed [7:0] out_midi_tone,
  output logic [15:0]       out_tone_freq,
  output logic [15:0]       out_tone_duration,
  output logic [7:0]        out_tone_volume,
  output logic              out_last_of_run,
  output logic              out_no_notes,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import mpsp_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] whole_r;
  logic [7:0]  vol_r;
  logic        en_r;
  logic [3:0]  oct_r, oct_nxt;
  logic [2:0]  len_r, len_nxt;
  logic        pend_r, pend_nxt;
  logic [3:0]  base_r, base_nxt;
  logic        any_r, any_nxt;

  slot_t       slots_r [2];
  slot_t       dec_slot [2];
  logic [1:0]  cnt_r, dec_cnt;
  logic        last_r;
  logic        nonotes_r, dec_nonotes;
  logic        idx_r;
  logic [15:0] freq_r;

  logic [7:0]  c_lc;
  logic        blank;
  logic [3:0]  lc;
  logic        consumed;
  logic signed [1:0] off;
  logic [15:0] dur_cur;

  logic        in_acc;
  logic        final_slot;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;
  logic [15:0] divisor;
  slot_t       cur;

  assign in_acc     = in_valid && !in_stall;
  assign cur        = slots_r[idx_r];
  assign final_slot = ({1'b0, idx_r} + 2'd1) == cnt_r;
  assign dur_cur    = whole_r >> len_r;
  assign divisor    = div_entry(cur.note) >> cur.oct;
  assign cfg_ready  = 1'b1;

  // character decode
  always_comb begin
    c_lc = (in_char_code inside {[8'h41:8'h5A]}) ? in_char_code + 8'd32 : in_char_code;
    blank = c_lc inside {[8'd9:8'd13], 8'd32};
    lc = len_code(c_lc);
    oct_nxt  = oct_r;
    len_nxt  = len_r;
    pend_nxt = pend_r;
    base_nxt = base_r;
    any_nxt  = any_r;
    dec_slot[0] = plain_slot(KIND_END, 16'd0);
    dec_slot[1] = plain_slot(KIND_END, 16'd0);
    dec_cnt     = 2'd0;
    dec_nonotes = 1'b0;
    consumed    = 1'b0;
    off         = 2'sd0;
    if (!en_r) begin
      if (in_end_of_string) begin
        dec_slot[0] = plain_slot(KIND_OFF, 16'd0);
        dec_cnt     = 2'd1;
        dec_nonotes = 1'b1;
        pend_nxt    = 1'b0;
        any_nxt     = 1'b0;
      end
    end else begin
      if (!blank) begin
        if (pend_r) begin
          if (c_lc == "+") begin
            off = 2'sd1;
            consumed = 1'b1;
          end else if (c_lc == "-") begin
            off = -2'sd1;
            consumed = 1'b1;
          end
          dec_slot[0] = note_slot(base_r, off, oct_r, dur_cur, vol_r);
          dec_cnt  = 2'd1;
          pend_nxt = 1'b0;
          any_nxt  = 1'b1;
        end
        if (!consumed) begin
          if (c_lc inside {[8'h30:8'h39]}) begin
            if (lc[3]) begin
              len_nxt = lc[2:0];
            end else begin
              dec_slot[dec_cnt[0]] = plain_slot(KIND_BAD, 16'd0);
              dec_cnt = dec_cnt + 2'd1;
            end
          end else if (c_lc inside {[8'h61:8'h67]}) begin
            base_nxt = letter_base(c_lc);
            pend_nxt = 1'b1;
          end else if (c_lc == "p") begin
            dec_slot[dec_cnt[0]] = plain_slot(KIND_REST, dur_cur);
            dec_cnt = dec_cnt + 2'd1;
            any_nxt = 1'b1;
          end else if (c_lc == "<") begin
            if (oct_r > OCT_MIN) oct_nxt = oct_r - 4'd1;
          end else if (c_lc == ">") begin
            if (oct_r < OCT_MAX) oct_nxt = oct_r + 4'd1;
          end else begin
            dec_slot[dec_cnt[0]] = plain_slot(KIND_BAD, 16'd0);
            dec_cnt = dec_cnt + 2'd1;
          end
        end
      end
      if (in_end_of_string) begin
        if (pend_nxt) begin
          dec_slot[dec_cnt[0]] = note_slot(base_nxt, 2'sd0, oct_nxt, whole_r >> len_nxt,
                                           vol_r);
          dec_cnt = dec_cnt + 2'd1;
          any_nxt = 1'b1;
        end
        if (dec_cnt == 2'd0) begin
          dec_slot[0] = plain_slot(KIND_END, 16'd0);
          dec_cnt = 2'd1;
        end
        dec_nonotes = !any_nxt;
        pend_nxt = 1'b0;
        any_nxt  = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && dec_cnt != 2'd0) begin
          state_nxt = (dec_slot[0].kind == KIND_NOTE) ? ST_LOAD : ST_OUT;
        end
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (final_slot) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = (slots_r[1].kind == KIND_NOTE) ? ST_LOAD : ST_OUT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    div_start = (state_r == ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      whole_r <= WHOLE_RST;
      vol_r   <= VOL_RST;
      en_r    <= 1'b1;
      oct_r   <= OCT_RST;
      len_r   <= LEN_RST;
      pend_r  <= 1'b0;
      base_r  <= 4'd0;
      any_r   <= 1'b0;
      cnt_r   <= 2'd0;
      last_r  <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WHOLE: whole_r <= cfg_wdata;
          CFG_VOL:   vol_r   <= cfg_wdata[7:0];
          CFG_EN:    en_r    <= cfg_wdata[0];
          default:   ;
        endcase
      end
      if (in_acc) begin
        oct_r  <= oct_nxt;
        len_r  <= len_nxt;
        pend_r <= pend_nxt;
        base_r <= base_nxt;
        any_r  <= any_nxt;
        cnt_r  <= dec_cnt;
        last_r <= in_end_of_string;
        idx_r  <= 1'b0;
      end else if (state_r == ST_OUT && !out_stall && !final_slot) begin
        idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slots_r[0] <= dec_slot[0];
      slots_r[1] <= dec_slot[1];
      nonotes_r  <= dec_nonotes;
    end
    if (div_done) begin
      freq_r <= div_q;
    end
  end

  mpsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_kind          = cur.kind;
  assign out_midi_tone     = cur.midi;
  assign out_tone_freq     = (cur.kind == KIND_NOTE) ? freq_r : 16'd0;
  assign out_tone_duration = cur.dur;
  assign out_tone_volume   = cur.vol;
  assign out_last_of_run   = final_slot && last_r;
  assign out_no_notes      = final_slot && last_r && nonotes_r;

endmodule

@@ sv/mpsp_checker.sv @@
// Port-level checker for the play-string parser, bound to the top level.
module mpsp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        out_kind,
  input logic signed [7:0] out_midi_tone,
  input logic [15:0]       out_tone_freq,
  input logic [7:0]        out_tone_volume,
  input logic              out_last_of_run
);
  import mpsp_pkg::*;

  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_of_run |=> !in_stall && !out_valid)
    else $error("not idle after final result");

  a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_NOTE |-> out_tone_freq != 16'd0 && out_midi_tone != -8'sd1)
    else $error("note result without frequency or tone");

  a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_NOTE |->
      out_tone_freq == 16'd0 && out_midi_tone == -8'sd1 && out_tone_volume == 8'd0)
    else $error("non-note result carries tone fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_tone_freq))
    else $error("stalled result changed");

endmodule

bind music_play_string_parser_top mpsp_checker u_mpsp_checker (.*);

@@ tb/music_play_string_parser_top_test.sv @@
`timescale 1ns / 100ps
// Testbench for the play-string parser: tone scoreboard class, stimulus tasks and top module.
module music_play_string_parser_top_test;
  import mpsp_pkg::*;

  typedef struct {
    kind_t             kind;
    logic signed [7:0] midi;
    logic [15:0]       freq;
    logic [15:0]       dur;
    logic [7:0]        vol;
    logic              last;
    logic              no_notes;
  } tone_rec_t;

  class tone_book;
    logic [15:0] whole_ms;
    logic [7:0]  vol_level;
    logic        sound_on;
    int          octave;
    int          len_shift;
    bit          held;
    int          held_base;
    bit          any_tone;
    int unsigned div_tab[14];
    tone_rec_t   tones_due[$];
    int          errors;
    int          kind_seen[5];

    function new();
      div_tab = '{19327, 18242, 17218, 16252, 15340, 14479, 13666,
                  12899, 12175, 11492, 10847, 10238, 9664, 9121};
      whole_ms  = WHOLE_RST;
      vol_level = VOL_RST;
      sound_on  = 1'b1;
      octave    = 4;
      len_shift = 2;
      held      = 0;
      held_base = 0;
      any_tone  = 0;
      errors    = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_WHOLE: whole_ms = val;
        CFG_VOL:   vol_level = val[7:0];
        CFG_EN:    sound_on = val[0];
        default:   ;
      endcase
    endfunction

    function void push_tone(kind_t k, logic signed [7:0] midi, logic [15:0] freq,
                            logic [15:0] dur, logic [7:0] vol);
      tone_rec_t t;
      t.kind     = k;
      t.midi     = midi;
      t.freq     = freq;
      t.dur      = dur;
      t.vol      = vol;
      t.last     = 1'b0;
      t.no_notes = 1'b0;
      tones_due.push_back(t);
    endfunction

    function logic [15:0] tone_len();
      return whole_ms >> len_shift;
    endfunction

    function void emit_held(int off);
      int          n;
      int unsigned d;
      n = held_base + off;
      if (n < 0) n = 0;
      if (n > 13) n = 13;
      d = div_tab[n] >> octave;
      push_tone(KIND_NOTE, 8'(n - 1 + octave * 12), 16'(1193180 / d), tone_len(), vol_level);
      held     = 0;
      any_tone = 1;
    endfunction

    function void close_string();
      int t;
      t = tones_due.size() - 1;
      tones_due[t].last     = 1'b1;
      tones_due[t].no_notes = !any_tone;
      held     = 0;
      any_tone = 0;
    endfunction

    // predicts the tones caused by one accepted character
    function void note_char(logic [7:0] ch, logic eos);
      logic [7:0] c;
      int         first;
      bit         taken;
      first = tones_due.size();
      if (!sound_on) begin
        if (eos) begin
          push_tone(KIND_OFF, -8'sd1, 16'd0, 16'd0, 8'd0);
          any_tone = 0;
          close_string();
        end
        return;
      end
      c = ch;
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (!((c >= 8'd9 && c <= 8'd13) || c == " ")) begin
        taken = 0;
        if (held) begin
          if (c == "+") begin
            emit_held(1);
            taken = 1;
          end else if (c == "-") begin
            emit_held(-1);
            taken = 1;
          end else begin
            emit_held(0);
          end
        end
        if (!taken) begin
          if (c >= "a" && c <= "g") begin
            case (c)
              "a":     held_base = 10;
              "b":     held_base = 12;
              "c":     held_base = 1;
              "d":     held_base = 3;
              "e":     held_base = 5;
              "f":     held_base = 6;
              default: held_base = 8;
            endcase
            held = 1;
          end else begin
            case (c)
              "1": len_shift = 0;
              "2": len_shift = 1;
              "4": len_shift = 2;
              "8": len_shift = 3;
              "6": len_shift = 4;
              "3": len_shift = 5;
              "p": begin
                push_tone(KIND_REST, -8'sd1, 16'd0, tone_len(), 8'd0);
                any_tone = 1;
              end
              "<": if (octave > 1) octave--;
              ">": if (octave < 8) octave++;
              default: push_tone(KIND_BAD, -8'sd1, 16'd0, 16'd0, 8'd0);
            endcase
          end
        end
      end
      if (eos) begin
        if (held) emit_held(0);
        if (tones_due.size() == first) push_tone(KIND_END, -8'sd1, 16'd0, 16'd0, 8'd0);
        close_string();
      end
    endfunction

    function void check_tone(tone_rec_t got);
      tone_rec_t want;
      if (tones_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result kind %0d with nothing expected", $realtime, got.kind);
        return;
      end
      want = tones_due.pop_front();
      kind_seen[int'(want.kind)]++;
      if (got.kind !== want.kind || got.midi !== want.midi || got.freq !== want.freq ||
          got.dur !== want.dur || got.vol !== want.vol || got.last !== want.last ||
          got.no_notes !== want.no_notes) begin
        errors++;
        if (errors <= 10) begin
          $write("%0t: mismatch (expected/actual) kind %0d/%0d midi %0d/%0d freq %0d/%0d",
                 $realtime, want.kind, got.kind, want.midi, got.midi, want.freq, got.freq);
          $display(" dur %0d/%0d vol %0d/%0d last %0b/%0b no_notes %0b/%0b",
                   want.dur, got.dur, want.vol, got.vol, want.last, got.last,
                   want.no_notes, got.no_notes);
        end
      end
    endfunction
  endclass

  localparam int LIMIT = 2_000_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_char_code = 8'd0;
  logic              in_end_of_string = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_kind;
  logic signed [7:0] out_midi_tone;
  logic [15:0]       out_tone_freq;
  logic [15:0]       out_tone_duration;
  logic [7:0]        out_tone_volume;
  logic              out_last_of_run;
  logic              out_no_notes;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_WHOLE;
  logic [15:0]       cfg_wdata = 16'd0;

  tone_book book;
  int       chars_sent = 0;
  int       strings_sent = 0;
  int       cycles = 0;
  bit       hold_req = 0;
  bit       steady = 0;

  music_play_string_parser_top dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               book.tones_due.size());
      $display("music_play_string_parser_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    tone_rec_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind     = kind_t'(out_kind);
      got.midi     = out_midi_tone;
      got.freq     = out_tone_freq;
      got.dur      = out_tone_duration;
      got.vol      = out_tone_volume;
      got.last     = out_last_of_run;
      got.no_notes = out_no_notes;
      book.check_tone(got);
    end
  end

  // receiver back-pressure
  initial begin
    int v;
    int len;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        v = 1;
        len = 400;
      end else if (steady) begin
        v = 0;
        len = 1;
      end else if ($urandom_range(0, 99) < 65) begin
        v = 0;
        len = $urandom_range(1, 8);
      end else begin
        v = 1;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      end
      out_stall <= v[0];
      repeat (len - 1) @(negedge clk);
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic eos);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = steady ? 0 : (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(15, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_char_code     <= ch;
    in_end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_char(ch, eos);
    chars_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_char();
    int         r;
    logic [7:0] letter;
    string      lens;
    lens   = "124863";
    r      = $urandom_range(0, 99);
    letter = 8'(8'd97 + $urandom_range(0, 6));
    if (r < 38) return $urandom_range(0, 1) ? letter : letter - 8'd32;
    if (r < 48) return $urandom_range(0, 1) ? "+" : "-";
    if (r < 60) return lens[$urandom_range(0, 5)];
    if (r < 68) return $urandom_range(0, 1) ? "<" : ">";
    if (r < 74) return $urandom_range(0, 1) ? "p" : "P";
    if (r < 80) return ($urandom_range(0, 5) == 0) ? 8'd32 : 8'(9 + $urandom_range(0, 4));
    if (r < 86) return 8'($urandom_range(33, 126));
    return 8'($urandom);
  endfunction

  task automatic send_random_string();
    int         n;
    logic [7:0] dir;
    n = $urandom_range(1, 12);
    // occasional octave sweep into a limit
    if ($urandom_range(0, 14) == 0) begin
      dir = $urandom_range(0, 1) ? "<" : ">";
      repeat (9) send_char(dir, 1'b0);
    end
    for (int i = 0; i < n; i++) send_char(pick_char(), i == n - 1);
  endtask

  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.tones_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] whole, input logic [7:0] vol, input logic en);
    settle(30);
    write_reg(CFG_WHOLE, whole);
    write_reg(CFG_VOL, {8'($urandom), vol});
    write_reg(CFG_EN, {15'($urandom), en});
  endtask

  task automatic run_phase(input int items, input bit squeeze);
    int  start;
    bit  held_off;
    bit  paused;
    start    = chars_sent;
    held_off = 0;
    paused   = 0;
    while (chars_sent - start < items) begin
      if (squeeze && !held_off && chars_sent - start > items / 3) begin
        hold_req = 1;
        held_off = 1;
      end
      if (squeeze && !paused && chars_sent - start > 2 * items / 3) begin
        settle(0);
        paused = 1;
      end
      send_random_string();
    end
  endtask

  initial begin
    book = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(" ", 1'b1);
    send_text("+C-8B+E");
    send_text("g\t5<P");
    send_text("f3");
    send_text(">p");

    apply_setting(16'hFFFF, 8'hFF, 1'b1);
    run_phase(350, 0);
    apply_setting(16'h0000, 8'h00, 1'b1);
    steady = 1;
    run_phase(250, 0);
    steady = 0;
    apply_setting(16'($urandom), 8'($urandom), 1'b1);
    run_phase(350, 1);
    apply_setting(16'($urandom), 8'($urandom), 1'b0);
    run_phase(150, 0);
    apply_setting(WHOLE_RST, VOL_RST, 1'b1);
    run_phase(350, 0);
    apply_setting(16'($urandom), 8'($urandom), 1'b1);
    run_phase(350, 0);

    settle(60);
    $display("covered %0d characters in %0d strings over seven register settings",
             chars_sent, strings_sent);
    $display("checked %0d notes, %0d rests, %0d bad, %0d end markers, %0d disabled",
             book.kind_seen[KIND_NOTE], book.kind_seen[KIND_REST], book.kind_seen[KIND_BAD],
             book.kind_seen[KIND_END], book.kind_seen[KIND_OFF]);
    if (book.errors == 0 && book.tones_due.size() == 0) begin
      $display("music_play_string_parser_top regression: pass");
    end else begin
      $display("%0d errors", book.errors);
      $display("music_play_string_parser_top regression: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/mpsp_pkg.sv
sv/mpsp_div.sv
sv/music_play_string_parser_top.sv
sv/mpsp_checker.sv
tb/music_play_string_parser_top_test.sv
